@@ sv/rgbhsv_pkg.sv @@
`default_nettype none

package rgbhsv_pkg;

  localparam int unsigned CH_W  = 8;   // one colour channel
  localparam int unsigned QUO_W = 8;   // quotient bits, one per divider step
  localparam int unsigned T_W   = 11;  // hue offset, 0 .. 6*diff-1
  localparam int unsigned HN_W  = 19;  // 255 * hue offset
  localparam int unsigned HD_W  = 11;  // 6 * diff
  localparam int unsigned SN_W  = 16;  // 255 * diff
  localparam int unsigned SD_W  = 8;   // maximum channel

  // Item carried through the divider pipeline. Both quotients are formed
  // in parallel, one bit per stage, by restoring division.
  typedef struct packed {
    logic [HN_W-1:0]  hue_rem;
    logic [HD_W-1:0]  hue_den;
    logic [QUO_W-1:0] hue_q;
    logic [SN_W-1:0]  sat_rem;
    logic [SD_W-1:0]  sat_den;
    logic [QUO_W-1:0] sat_q;
    logic [CH_W-1:0]  brightness;
    logic [CH_W-1:0]  alpha;
    logic             hue_zero;
    logic             sat_zero;
  } div_item_t;

endpackage

`default_nettype wire

@@ sv/rgbhsv_front.sv @@
`default_nettype none

module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CH_W-1:0] in_red,
  input  wire logic [CH_W-1:0] in_green,
  input  wire logic [CH_W-1:0] in_blue,
  input  wire logic [CH_W-1:0] in_alpha,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output div_item_t            out_item
);

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  // Stage 1: maximum, minimum and the winning channel.
  logic            v1_r;
  logic            rdy1;
  logic [CH_W-1:0] r1_r, g1_r, b1_r, a1_r, mx1_r, mn1_r;
  sel_t            sel1_r;
  logic [CH_W-1:0] mx_nxt, mn_nxt, rg_max, rg_min;
  sel_t            sel_nxt;

  // Stage 2: chroma and the hue offset, folded into 0 .. 6*diff-1.
  logic            v2_r;
  logic            rdy2;
  logic [CH_W-1:0] d2_r, mx2_r, a2_r;
  logic [T_W-1:0]  t2_r;
  logic [CH_W-1:0] d_nxt;
  logic signed [T_W:0] t_raw, t_six, t_nxt;

  // Stage 3: numerators and denominators for the divider.
  logic            v3_r;
  logic            rdy3;
  div_item_t       item3_r;
  div_item_t       item_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    rg_max = (in_red >= in_green) ? in_red : in_green;
    rg_min = (in_red <= in_green) ? in_red : in_green;
    mx_nxt = (rg_max >= in_blue) ? rg_max : in_blue;
    mn_nxt = (rg_min <= in_blue) ? rg_min : in_blue;
    // Ties go to red first, then green.
    if (mx_nxt == in_red) begin
      sel_nxt = SEL_RED;
    end else if (mx_nxt == in_green) begin
      sel_nxt = SEL_GREEN;
    end else begin
      sel_nxt = SEL_BLUE;
    end
  end

  always_comb begin
    d_nxt = mx1_r - mn1_r;
    t_six = signed'({2'b00, 1'b0, d_nxt, 1'b0}) + signed'({2'b00, d_nxt, 2'b00});
    case (sel1_r)
      SEL_RED: begin
        t_raw = signed'({4'b0000, g1_r}) - signed'({4'b0000, b1_r});
      end
      SEL_GREEN: begin
        t_raw = signed'({3'b000, d_nxt, 1'b0}) + signed'({4'b0000, b1_r})
              - signed'({4'b0000, r1_r});
      end
      SEL_BLUE: begin
        t_raw = signed'({2'b00, d_nxt, 2'b00}) + signed'({4'b0000, r1_r})
              - signed'({4'b0000, g1_r});
      end
      default: begin
        t_raw = '0;
      end
    endcase
    t_nxt = t_raw[T_W] ? (t_raw + t_six) : t_raw;
  end

  always_comb begin
    item_nxt            = '0;
    item_nxt.hue_rem    = (HN_W'(t2_r) << CH_W) - HN_W'(t2_r);
    item_nxt.hue_den    = (HD_W'(d2_r) << 2) + (HD_W'(d2_r) << 1);
    item_nxt.hue_q      = '0;
    item_nxt.sat_rem    = (SN_W'(d2_r) << CH_W) - SN_W'(d2_r);
    item_nxt.sat_den    = mx2_r;
    item_nxt.sat_q      = '0;
    item_nxt.brightness = mx2_r;
    item_nxt.alpha      = a2_r;
    item_nxt.hue_zero   = (d2_r == '0);
    item_nxt.sat_zero   = (mx2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r1_r   <= in_red;
      g1_r   <= in_green;
      b1_r   <= in_blue;
      a1_r   <= in_alpha;
      mx1_r  <= mx_nxt;
      mn1_r  <= mn_nxt;
      sel1_r <= sel_nxt;
    end
    if (rdy2 && v1_r) begin
      d2_r  <= d_nxt;
      mx2_r <= mx1_r;
      a2_r  <= a1_r;
      t2_r  <= t_nxt[T_W-1:0];
    end
    if (rdy3 && v2_r) begin
      item3_r <= item_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = item3_r;

endmodule

`default_nettype wire

@@ sv/rgbhsv_div_step.sv @@
`default_nettype none

module rgbhsv_div_step
  import rgbhsv_pkg::*;
#(
  parameter int unsigned BIT = 0
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire div_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output div_item_t      out_item
);

  logic            valid_r;
  div_item_t       item_r;
  div_item_t       item_nxt;
  logic [HN_W-1:0] hue_trial;
  logic [SN_W-1:0] sat_trial;

  assign in_ready = !valid_r || out_ready;

  // While the divisor is non-zero the remainder stays below it shifted one
  // place further, so a single compare and subtract settles this quotient bit.
  always_comb begin
    item_nxt  = in_item;
    hue_trial = HN_W'(in_item.hue_den) << BIT;
    sat_trial = SN_W'(in_item.sat_den) << BIT;
    if (in_item.hue_rem >= hue_trial) begin
      item_nxt.hue_rem    = in_item.hue_rem - hue_trial;
      item_nxt.hue_q[BIT] = 1'b1;
    end
    if (in_item.sat_rem >= sat_trial) begin
      item_nxt.sat_rem    = in_item.sat_rem - sat_trial;
      item_nxt.sat_q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

@@ sv/rgb_to_hsv_pixel_convert.sv @@
// RGBA to HSV pixel converter, 8 bits per channel.
// Input stream: in_tdata carries one RGBA pixel per transaction, accepted
// when in_tvalid and in_tready are both high. Output stream: out_tdata
// carries hue, saturation, brightness (the largest channel) and the alpha
// copied through; a transaction completes when out_tvalid and out_tready
// are both high. Hue maps a full turn to 0..254; a grey pixel gives hue 0,
// and a black pixel also gives saturation 0.
// From acceptance to out_tvalid a pixel passes three front stages
// (max/min, hue offset, numerators) and eight restoring divider stages,
// one quotient bit of both divisions per stage.
// Throughput is one pixel per cycle while out_tready is high. Every stage
// holds a valid bit and takes a new transaction whenever it is empty or its
// successor moves on, so empty slots close up while the output is stalled,
// and the input is refused only once all eleven stages hold pixels.
// A stall holds every occupied stage unchanged; nothing is dropped or
// repeated. Synchronous active-low reset empties the pipeline; no state
// survives between pixels.
`default_nettype none

module rgb_to_hsv_pixel_convert
  import rgbhsv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // red, green, blue, alpha
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // hue, saturation, brightness, alpha_out
);

  logic      vld [QUO_W+1];
  logic      rdy [QUO_W+1];
  div_item_t itm [QUO_W+1];

  rgbhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_red    (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_blue   (in_tdata[23:16]),
    .in_alpha  (in_tdata[31:24]),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_item  (itm[0])
  );

  // Quotient bits are resolved from the most significant down.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rgbhsv_div_step #(
      .BIT (QUO_W - 1 - k)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_item   (itm[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_item  (itm[k+1])
    );
  end

  logic [CH_W-1:0] hue_out, sat_out;

  assign hue_out = itm[QUO_W].hue_zero ? '0 : itm[QUO_W].hue_q;
  assign sat_out = itm[QUO_W].sat_zero ? '0 : itm[QUO_W].sat_q;

  assign rdy[QUO_W]  = out_tready;
  assign out_tvalid  = vld[QUO_W];
  assign out_tdata   = {itm[QUO_W].alpha, itm[QUO_W].brightness, sat_out, hue_out};

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] != 8'hFF))
    else $error("hue reached a full turn");

  a_black_unsaturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[23:16] == 8'h00)) |-> (out_tdata[15:8] == 8'h00))
    else $error("black pixel with non-zero saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[15:8] == 8'h00)) |-> (out_tdata[7:0] == 8'h00))
    else $error("grey pixel with non-zero hue");

  a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("pipeline refused input while the output drains");
`endif

endmodule

`default_nettype wire

@@ tb/sv/rgb_to_hsv_pixel_convert_test.sv @@
`default_nettype none

module rgb_to_hsv_pixel_convert_test
  import rgbhsv_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned DRAIN_EVERY  = 600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_EVERY   = 800;

  typedef logic [CH_W-1:0] channel_t;

  // Packed from the top down, so that the last field, red, sits in the lowest bits.
  typedef struct packed {
    channel_t alpha;
    channel_t blue;
    channel_t green;
    channel_t red;
  } rgba_t;

  typedef struct packed {
    channel_t alpha_out;
    channel_t brightness;
    channel_t saturation;
    channel_t hue;
  } hsv_t;

  typedef struct {
    rgba_t pixel;
    bit    wait_for_empty;
  } pending_pixel_t;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_MOSTLY,
    READY_RARELY
  } ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // red, green, blue, alpha
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // hue, saturation, brightness, alpha_out

  pending_pixel_t pixel_queue[$];
  hsv_t           hsv_expect[$];
  int unsigned    mismatches = 0;
  int unsigned    results_seen = 0;
  int unsigned    cycle_count = 0;

  rgb_to_hsv_pixel_convert DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact integer form of the conversion: every quotient is a non-negative
  // rational, so truncating division gives its floor.
  function automatic hsv_t hsv_of(rgba_t px);
    int   r, g, b, top, bottom, diff, offset;
    hsv_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    top = (r > g) ? r : g;
    if (b > top) top = b;
    bottom = (r < g) ? r : g;
    if (b < bottom) bottom = b;
    diff = top - bottom;
    res = '0;
    res.brightness = channel_t'(top);
    res.alpha_out = px.alpha;
    if (diff != 0) begin
      // Ties on the maximum go to red first, then green.
      if (top == r) offset = g - b;
      else if (top == g) offset = 2 * diff + b - r;
      else offset = 4 * diff + r - g;
      if (offset < 0) offset += 6 * diff;
      res.hue = channel_t'((255 * offset) / (6 * diff));
    end
    if (top != 0) res.saturation = channel_t'((255 * diff) / top);
    return res;
  endfunction

  function automatic channel_t channel_near(int base);
    int v;
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return channel_t'(v);
  endfunction

  function automatic rgba_t random_pixel();
    rgba_t px;
    int    kind, base;
    px = rgba_t'($urandom);
    kind = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    case (kind)
      4: begin
        px.red = channel_t'(base);
        px.green = channel_t'(base);
        px.blue = channel_t'(base);
      end
      5: begin
        // Two channels are made equal.
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue = px.red;
          default: px.blue = px.green;
        endcase
      end
      6: begin
        px.red = channel_t'($urandom_range(0, 3));
        px.green = channel_t'($urandom_range(0, 3));
        px.blue = channel_t'($urandom_range(0, 3));
      end
      7: begin
        px.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hfe : 8'h01;
        px.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      8: begin
        px.red = channel_near(base);
        px.green = channel_near(base);
        px.blue = channel_near(base);
      end
      9: begin
        case ($urandom_range(0, 2))
          0: px.red = 8'hff;
          1: px.green = 8'hff;
          default: px.blue = 8'hff;
        endcase
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic add_pixel(channel_t r, channel_t g, channel_t b, channel_t a);
    pending_pixel_t item;
    item.pixel = {a, b, g, r};
    item.wait_for_empty = 1'b0;
    pixel_queue.push_back(item);
  endtask

  // Sender: bursts of random length separated by random gaps. An item marked
  // wait_for_empty is held back until every outstanding result has arrived.
  int unsigned    burst_left = 8;
  int unsigned    gap_left = 0;
  bit             draining = 1'b0;
  bit             drained = 1'b0;
  pending_pixel_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (draining) begin
        // The decision is taken at a later edge than the last transaction,
        // so the expectation for it is already queued.
        if (hsv_expect.size() == 0) begin
          draining = 1'b0;
          drained = 1'b1;
        end
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pixel_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pixel_queue[0].wait_for_empty && !drained) begin
        draining = 1'b1;
        in_tvalid <= 1'b0;
      end else begin
        next_item = pixel_queue.pop_front();
        drained = 1'b0;
        in_tdata <= next_item.pixel;
        in_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: its own stall pattern, changed every so often, plus a long
  // hold-off now and then so that the pipeline fills and refuses input.
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 300;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (results_seen >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      next_hold_at += HOLD_EVERY;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        READY_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
        default:      out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: queues the expected result of every accepted pixel and checks
  // every completed output transaction against the oldest one.
  hsv_t want, got;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) hsv_expect.push_back(hsv_of(rgba_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = hsv_t'(out_tdata);
        if (hsv_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: out_tdata %h", out_tdata);
        end else begin
          want = hsv_expect.pop_front();
          if (got.hue !== want.hue || got.saturation !== want.saturation ||
              got.brightness !== want.brightness || got.alpha_out !== want.alpha_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected h %0d s %0d v %0d a %0d, got h %0d s %0d v %0d a %0d",
                       want.hue, want.saturation, want.brightness, want.alpha_out,
                       got.hue, got.saturation, got.brightness, got.alpha_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pending_pixel_t item;
    int unsigned    i;
    // Black, white and grey pixels.
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    add_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    add_pixel(8'h80, 8'h80, 8'h80, 8'haa);
    add_pixel(8'h01, 8'h01, 8'h01, 8'h55);
    // Primaries; pure red must give hue 0.
    add_pixel(8'hff, 8'h00, 8'h00, 8'h01);
    add_pixel(8'h00, 8'hff, 8'h00, 8'h80);
    add_pixel(8'h00, 8'h00, 8'hff, 8'hfe);
    // Ties on the maximum.
    add_pixel(8'hff, 8'hff, 8'h00, 8'h0f);
    add_pixel(8'h00, 8'hff, 8'hff, 8'hf0);
    add_pixel(8'hff, 8'h00, 8'hff, 8'h33);
    add_pixel(8'h40, 8'h40, 8'h10, 8'hcc);
    // Red maximum with blue above green wraps round to the top of the range.
    add_pixel(8'hff, 8'h00, 8'h01, 8'h00);
    add_pixel(8'hff, 8'h00, 8'h0a, 8'h11);
    // Small maxima and low saturation.
    add_pixel(8'h01, 8'h00, 8'h00, 8'h22);
    add_pixel(8'h00, 8'h01, 8'h00, 8'h44);
    add_pixel(8'h00, 8'h00, 8'h01, 8'h88);
    add_pixel(8'h01, 8'h01, 8'h00, 8'h77);
    add_pixel(8'hff, 8'hfe, 8'hfe, 8'hee);
    add_pixel(8'h0a, 8'h14, 8'h1e, 8'h99);
    add_pixel(8'hc8, 8'h64, 8'h32, 8'h66);
    add_pixel(8'h32, 8'hc8, 8'h64, 8'hdd);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      item.pixel = random_pixel();
      item.wait_for_empty = (i % DRAIN_EVERY == 0);
      pixel_queue.push_back(item);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pixel_queue.size() != 0 || in_tvalid) @(negedge clk);
    while (hsv_expect.size() != 0) @(negedge clk);
    // Room for any stray result behind the last expected one.
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
